// ===== rtl/core/planar_pose_rollout_assert.svh =====
// Assertion macros for the planar pose integrator.
// Used by planar_pose_rollout.sv; expects clk and rst_n in the including scope.
`ifndef PLANAR_POSE_ROLLOUT_ASSERT_SVH
`define PLANAR_POSE_ROLLOUT_ASSERT_SVH
`ifndef SYNTHESIS
// Checked outside reset only.
`define PPR_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Checked at every edge, reset included.
`define PPR_ASSERT_RST(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define PPR_ASSERT(label, prop, msg)
`define PPR_ASSERT_RST(label, prop, msg)
`endif
`endif

// ===== rtl/core/ppr_pkg.sv =====
// Shared types, constants and the arctangent table of the pose integrator.
// No dependencies; used by every other file of the block but the assertion header.
`default_nettype none

package ppr_pkg;

  localparam int CORDIC_STEPS_DEFAULT = 24;
  localparam int ATAN_LEN = 30;
  localparam int ITER_W = 5;
  localparam int DATA_W = 32;
  localparam int CORDIC_W = 34;

  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_STEP = 1'b1;

  // Angles: pi and 2*pi in Q4.28, pi and pi/2 in Q30.
  localparam logic signed [DATA_W-1:0] PI_Q28 = 32'sd843314857;
  localparam logic signed [DATA_W-1:0] TWO_PI_Q28 = 32'sd1686629713;
  localparam logic signed [CORDIC_W-1:0] PI_Q30 = 34'sd3373259426;
  localparam logic signed [CORDIC_W-1:0] HALF_PI_Q30 = 34'sd1686629713;
  localparam logic signed [CORDIC_W-1:0] GAIN_Q30 = 34'sd652032874;

  localparam logic [DATA_W-1:0] SAMPLE_PERIOD_RST = 32'd42949673;

  typedef enum logic [3:0] {
    ST_IDLE, ST_DECODE, ST_WRAP, ST_PREP, ST_ROTATE,
    ST_MUL_VXC, ST_MUL_VYS, ST_MUL_VXS, ST_MUL_VYC,
    ST_MUL_DX, ST_MUL_DY, ST_MUL_W, ST_ROUND_Q, ST_UPDATE, ST_FINISH
  } ppr_state_t;

  typedef enum logic [2:0] {
    MUL_NONE, MUL_VX_C, MUL_VY_S, MUL_VX_S, MUL_VY_C, MUL_DX_TS, MUL_DY_TS, MUL_W_TS
  } mul_sel_t;

  typedef enum logic [2:0] {
    ACC_NONE, ACC_LOAD, ACC_DX, ACC_DY, ACC_SX, ACC_SY, ACC_SQ
  } acc_op_t;

  typedef struct packed {
    logic              accept;
    logic              wrap;
    logic              prep;
    logic              rotate;
    logic [ITER_W-1:0] iter;
    mul_sel_t          mul_sel;
    acc_op_t           acc_op;
    logic              update;
    logic              finish;
  } ppr_cmd_t;

  typedef struct packed {
    logic step_item;
  } ppr_status_t;

  // atan(2^-i) in Q30.
  function automatic logic [DATA_W-1:0] atan_q30(input logic [ITER_W-1:0] idx);
    logic [DATA_W-1:0] r;
    unique case (idx)
      5'd0:  r = 32'h3243F6A8;
      5'd1:  r = 32'h1DAC6705;
      5'd2:  r = 32'h0FADBAFC;
      5'd3:  r = 32'h07F56EA6;
      5'd4:  r = 32'h03FEAB76;
      5'd5:  r = 32'h01FFD55B;
      5'd6:  r = 32'h00FFFAAA;
      5'd7:  r = 32'h007FFF55;
      5'd8:  r = 32'h003FFFEA;
      5'd9:  r = 32'h001FFFFD;
      5'd10: r = 32'h000FFFFF;
      5'd11: r = 32'h0007FFFF;
      5'd12: r = 32'h0003FFFF;
      5'd13: r = 32'h0001FFFF;
      5'd14: r = 32'h0000FFFF;
      5'd15: r = 32'h00007FFF;
      5'd16: r = 32'h00003FFF;
      5'd17: r = 32'h00001FFF;
      5'd18: r = 32'h00000FFF;
      5'd19: r = 32'h000007FF;
      5'd20: r = 32'h000003FF;
      5'd21: r = 32'h000001FF;
      5'd22: r = 32'h000000FF;
      5'd23: r = 32'h0000007F;
      5'd24: r = 32'h0000003F;
      5'd25: r = 32'h0000001F;
      5'd26: r = 32'h0000000F;
      5'd27: r = 32'h00000008;
      5'd28: r = 32'h00000004;
      5'd29: r = 32'h00000002;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/ppr_in_if.sv =====
// Request channel of the pose integrator: valid/ready plus the request fields.
// Depends on ppr_pkg for the field width.
`default_nettype none

interface ppr_in_if;
  logic                                valid;
  logic                                ready;
  logic                                command;
  logic signed [ppr_pkg::DATA_W-1:0]   pose_x;
  logic signed [ppr_pkg::DATA_W-1:0]   pose_y;
  logic signed [ppr_pkg::DATA_W-1:0]   pose_yaw;
  logic signed [ppr_pkg::DATA_W-1:0]   vel_x;
  logic signed [ppr_pkg::DATA_W-1:0]   vel_y;
  logic signed [ppr_pkg::DATA_W-1:0]   yaw_rate;

  modport source (output valid, command, pose_x, pose_y, pose_yaw, vel_x, vel_y, yaw_rate,
                  input ready);
  modport sink (input valid, command, pose_x, pose_y, pose_yaw, vel_x, vel_y, yaw_rate,
                output ready);
endinterface

`default_nettype wire

// ===== rtl/core/ppr_out_if.sv =====
// Result channel of the pose integrator: valid/ready plus the pose fields.
// Depends on ppr_pkg for the field width.
`default_nettype none

interface ppr_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [ppr_pkg::DATA_W-1:0]   out_x;
  logic signed [ppr_pkg::DATA_W-1:0]   out_y;
  logic signed [ppr_pkg::DATA_W-1:0]   out_yaw;
  logic                                saturated;

  modport source (output valid, out_x, out_y, out_yaw, saturated, input ready);
  modport sink (input valid, out_x, out_y, out_yaw, saturated, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/ppr_ctrl.sv =====
// Sequencer of the pose integrator: walks a request through wrap, CORDIC and multiply steps.
// Depends on ppr_pkg; drives the datapath through ppr_cmd_t.
`default_nettype none

module ppr_ctrl #(
  parameter int CORDIC_STEPS = ppr_pkg::CORDIC_STEPS_DEFAULT
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  output logic                 out_valid,
  input  logic                 out_ready,
  input  ppr_pkg::ppr_status_t status,
  output ppr_pkg::ppr_cmd_t    cmd
);

  localparam logic [ppr_pkg::ITER_W-1:0] LAST_ITER = ppr_pkg::ITER_W'(CORDIC_STEPS - 1);

  ppr_pkg::ppr_state_t           state_r, state_nxt;
  logic [ppr_pkg::ITER_W-1:0]    iter_r, iter_nxt;
  logic                          out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ppr_pkg::ST_IDLE;
      iter_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      iter_r      <= iter_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    iter_nxt  = iter_r;
    in_ready  = 1'b0;
    cmd       = '0;
    unique case (state_r)
      ppr_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_nxt  = ppr_pkg::ST_DECODE;
        end
      end
      ppr_pkg::ST_DECODE: begin
        state_nxt = status.step_item ? ppr_pkg::ST_WRAP : ppr_pkg::ST_FINISH;
      end
      ppr_pkg::ST_WRAP: begin
        cmd.wrap  = 1'b1;
        state_nxt = ppr_pkg::ST_PREP;
      end
      ppr_pkg::ST_PREP: begin
        cmd.prep  = 1'b1;
        iter_nxt  = '0;
        state_nxt = ppr_pkg::ST_ROTATE;
      end
      ppr_pkg::ST_ROTATE: begin
        cmd.rotate = 1'b1;
        cmd.iter   = iter_r;
        iter_nxt   = ppr_pkg::ITER_W'(iter_r + 1'b1);
        if (iter_r == LAST_ITER) begin
          state_nxt = ppr_pkg::ST_MUL_VXC;
        end
      end
      ppr_pkg::ST_MUL_VXC: begin
        cmd.mul_sel = ppr_pkg::MUL_VX_C;
        state_nxt   = ppr_pkg::ST_MUL_VYS;
      end
      ppr_pkg::ST_MUL_VYS: begin
        cmd.mul_sel = ppr_pkg::MUL_VY_S;
        cmd.acc_op  = ppr_pkg::ACC_LOAD;
        state_nxt   = ppr_pkg::ST_MUL_VXS;
      end
      ppr_pkg::ST_MUL_VXS: begin
        cmd.mul_sel = ppr_pkg::MUL_VX_S;
        cmd.acc_op  = ppr_pkg::ACC_DX;
        state_nxt   = ppr_pkg::ST_MUL_VYC;
      end
      ppr_pkg::ST_MUL_VYC: begin
        cmd.mul_sel = ppr_pkg::MUL_VY_C;
        cmd.acc_op  = ppr_pkg::ACC_LOAD;
        state_nxt   = ppr_pkg::ST_MUL_DX;
      end
      ppr_pkg::ST_MUL_DX: begin
        cmd.mul_sel = ppr_pkg::MUL_DX_TS;
        cmd.acc_op  = ppr_pkg::ACC_DY;
        state_nxt   = ppr_pkg::ST_MUL_DY;
      end
      ppr_pkg::ST_MUL_DY: begin
        cmd.mul_sel = ppr_pkg::MUL_DY_TS;
        cmd.acc_op  = ppr_pkg::ACC_SX;
        state_nxt   = ppr_pkg::ST_MUL_W;
      end
      ppr_pkg::ST_MUL_W: begin
        cmd.mul_sel = ppr_pkg::MUL_W_TS;
        cmd.acc_op  = ppr_pkg::ACC_SY;
        state_nxt   = ppr_pkg::ST_ROUND_Q;
      end
      ppr_pkg::ST_ROUND_Q: begin
        cmd.acc_op = ppr_pkg::ACC_SQ;
        state_nxt  = ppr_pkg::ST_UPDATE;
      end
      ppr_pkg::ST_UPDATE: begin
        cmd.update = 1'b1;
        state_nxt  = ppr_pkg::ST_FINISH;
      end
      ppr_pkg::ST_FINISH: begin
        // Wait here while the previous result is still unclaimed.
        if (!out_valid_r || out_ready) begin
          cmd.finish = 1'b1;
          state_nxt  = ppr_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = ppr_pkg::ST_IDLE;
      end
    endcase
    out_valid_nxt = cmd.finish | (out_valid_r & ~out_ready);
  end

  assign out_valid = out_valid_r;

endmodule

`default_nettype wire

// ===== rtl/core/ppr_datapath.sv =====
// Datapath of the pose integrator: pose state, CORDIC, shared multiplier, rounding, saturation.
// Depends on ppr_pkg; controlled by ppr_ctrl through ppr_cmd_t.
`default_nettype none

module ppr_datapath (
  input  logic                              clk,
  input  logic                              rst_n,
  input  ppr_pkg::ppr_cmd_t                 cmd,
  output ppr_pkg::ppr_status_t              status,
  input  logic                              in_command,
  input  logic signed [ppr_pkg::DATA_W-1:0] in_pose_x,
  input  logic signed [ppr_pkg::DATA_W-1:0] in_pose_y,
  input  logic signed [ppr_pkg::DATA_W-1:0] in_pose_yaw,
  input  logic signed [ppr_pkg::DATA_W-1:0] in_vel_x,
  input  logic signed [ppr_pkg::DATA_W-1:0] in_vel_y,
  input  logic signed [ppr_pkg::DATA_W-1:0] in_yaw_rate,
  input  logic                              cfg_wr_en,
  input  logic [ppr_pkg::DATA_W-1:0]        cfg_wr_data,
  output logic signed [ppr_pkg::DATA_W-1:0] out_x,
  output logic signed [ppr_pkg::DATA_W-1:0] out_y,
  output logic signed [ppr_pkg::DATA_W-1:0] out_yaw,
  output logic                              saturated
);

  localparam int CW = ppr_pkg::CORDIC_W;
  localparam int OPW = 33;          // multiplier operand width
  localparam int PW = 2 * OPW;      // product width
  localparam int DW = 36;           // velocity term after Q46 -> Q16 reduction
  localparam int SW = 34;           // scaled position increment
  localparam int QW = 45;           // scaled yaw increment
  localparam int TW = 46;           // widest sum before saturation

  localparam logic signed [PW-1:0] RND_Q30 = 66'sd536870912;
  localparam logic [63:0] RND_SHIFT32 = 64'h0000_0000_8000_0000;
  localparam logic [63:0] RND_SHIFT20 = 64'h0000_0000_0008_0000;
  localparam logic signed [TW-1:0] SAT_MAX = 46'sd2147483647;
  localparam logic signed [TW-1:0] SAT_MIN = -46'sd2147483648;

  function automatic logic signed [31:0] sat_val(input logic signed [TW-1:0] v);
    logic signed [31:0] r;
    if (v > SAT_MAX) begin
      r = 32'sh7FFFFFFF;
    end else if (v < SAT_MIN) begin
      r = 32'sh80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  function automatic logic sat_hit(input logic signed [TW-1:0] v);
    return (v > SAT_MAX) || (v < SAT_MIN);
  endfunction

  // State with a defined reset.
  logic [ppr_pkg::DATA_W-1:0]        ts_r;
  logic signed [ppr_pkg::DATA_W-1:0] pos_x_r, pos_y_r, heading_r;

  // Working registers.
  logic                              step_r;
  logic signed [ppr_pkg::DATA_W-1:0] vx_r, vy_r, w_r, yaw_r;
  logic signed [CW-1:0]              x_r, y_r, z_r;
  logic                              neg_r;
  logic signed [PW-1:0]              prod_r, acc_r;
  logic signed [DW-1:0]              dx_r, dy_r;
  logic signed [SW-1:0]              ddx_r, ddy_r;
  logic signed [QW-1:0]              ddq_r;
  logic                              sat_r;
  logic signed [ppr_pkg::DATA_W-1:0] out_x_r, out_y_r, out_yaw_r;
  logic                              out_sat_r;

  // Next values.
  logic signed [32:0]                yaw_wide;
  logic signed [ppr_pkg::DATA_W-1:0] yaw_nxt;
  logic signed [CW-1:0]              z_start, z_prep_nxt;
  logic                              neg_nxt;
  logic signed [CW-1:0]              x_sh, y_sh, atan_v, x_nxt, y_nxt, z_nxt;
  logic signed [CW-1:0]              cos_v, sin_v;
  logic [DW-1:0]                     abs_dx, abs_dy;
  logic [31:0]                       mag_dx, mag_dy, mag_w;
  logic signed [OPW-1:0]             mul_a, mul_b;
  logic signed [PW-1:0]              prod_nxt, acc_sum, acc_rnd;
  logic signed [DW-1:0]              term_nxt;
  logic [63:0]                       sc_sum, q_sum;
  logic [SW-1:0]                     p_xy;
  logic [QW-1:0]                     p_q;
  logic signed [SW-1:0]              ddx_nxt, ddy_nxt;
  logic signed [QW-1:0]              ddq_nxt;
  logic signed [TW-1:0]              sum_x, sum_y, sum_q;

  always_comb begin
    // Single wrap of the stored heading into [-pi, pi].
    priority if (heading_r > ppr_pkg::PI_Q28) begin
      yaw_wide = 33'(heading_r) - 33'(ppr_pkg::TWO_PI_Q28);
    end else if (heading_r < -ppr_pkg::PI_Q28) begin
      yaw_wide = 33'(heading_r) + 33'(ppr_pkg::TWO_PI_Q28);
    end else begin
      yaw_wide = 33'(heading_r);
    end
    yaw_nxt = yaw_wide[31:0];

    // Fold the angle into the CORDIC convergence range.
    z_start = {yaw_r, 2'b00};
    priority if (z_start > ppr_pkg::HALF_PI_Q30) begin
      z_prep_nxt = z_start - ppr_pkg::PI_Q30;
      neg_nxt    = 1'b1;
    end else if (z_start < -ppr_pkg::HALF_PI_Q30) begin
      z_prep_nxt = z_start + ppr_pkg::PI_Q30;
      neg_nxt    = 1'b1;
    end else begin
      z_prep_nxt = z_start;
      neg_nxt    = 1'b0;
    end

    // One CORDIC micro-rotation.
    x_sh   = x_r >>> cmd.iter;
    y_sh   = y_r >>> cmd.iter;
    atan_v = CW'({1'b0, ppr_pkg::atan_q30(cmd.iter)});
    if (!z_r[CW-1]) begin
      x_nxt = x_r - y_sh;
      y_nxt = y_r + x_sh;
      z_nxt = z_r - atan_v;
    end else begin
      x_nxt = x_r + y_sh;
      y_nxt = y_r - x_sh;
      z_nxt = z_r + atan_v;
    end

    cos_v = neg_r ? -x_r : x_r;
    sin_v = neg_r ? -y_r : y_r;

    // Magnitudes for the period scaling, capped at 32 bits.
    abs_dx = dx_r[DW-1] ? DW'(-dx_r) : DW'(dx_r);
    abs_dy = dy_r[DW-1] ? DW'(-dy_r) : DW'(dy_r);
    mag_dx = (abs_dx > 36'h0_FFFF_FFFF) ? 32'hFFFF_FFFF : abs_dx[31:0];
    mag_dy = (abs_dy > 36'h0_FFFF_FFFF) ? 32'hFFFF_FFFF : abs_dy[31:0];
    mag_w  = w_r[31] ? 32'(-w_r) : 32'(w_r);

    unique case (cmd.mul_sel)
      ppr_pkg::MUL_VX_C:  begin mul_a = OPW'(vx_r); mul_b = cos_v[OPW-1:0]; end
      ppr_pkg::MUL_VY_S:  begin mul_a = OPW'(vy_r); mul_b = sin_v[OPW-1:0]; end
      ppr_pkg::MUL_VX_S:  begin mul_a = OPW'(vx_r); mul_b = sin_v[OPW-1:0]; end
      ppr_pkg::MUL_VY_C:  begin mul_a = OPW'(vy_r); mul_b = cos_v[OPW-1:0]; end
      ppr_pkg::MUL_DX_TS: begin mul_a = {1'b0, mag_dx}; mul_b = {1'b0, ts_r}; end
      ppr_pkg::MUL_DY_TS: begin mul_a = {1'b0, mag_dy}; mul_b = {1'b0, ts_r}; end
      ppr_pkg::MUL_W_TS:  begin mul_a = {1'b0, mag_w}; mul_b = {1'b0, ts_r}; end
      default:            begin mul_a = '0; mul_b = '0; end
    endcase
    prod_nxt = mul_a * mul_b;

    // Q46 velocity term to Q16.16, rounded half up.
    acc_sum  = (cmd.acc_op == ppr_pkg::ACC_DX) ? (acc_r - prod_r) : (acc_r + prod_r);
    acc_rnd  = acc_sum + RND_Q30;
    term_nxt = acc_rnd[PW-1:30];

    // Magnitude rounding with ties away from zero, sign restored after.
    sc_sum  = prod_r[63:0] + RND_SHIFT32;
    p_xy    = {2'b00, sc_sum[63:32]};
    ddx_nxt = dx_r[DW-1] ? -p_xy : p_xy;
    ddy_nxt = dy_r[DW-1] ? -p_xy : p_xy;
    q_sum   = prod_r[63:0] + RND_SHIFT20;
    p_q     = {1'b0, q_sum[63:20]};
    ddq_nxt = w_r[31] ? -p_q : p_q;

    sum_x = TW'(pos_x_r) + TW'(ddx_r);
    sum_y = TW'(pos_y_r) + TW'(ddy_r);
    sum_q = TW'(yaw_r) + TW'(ddq_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ts_r      <= ppr_pkg::SAMPLE_PERIOD_RST;
      pos_x_r   <= '0;
      pos_y_r   <= '0;
      heading_r <= '0;
    end else begin
      if (cfg_wr_en) begin
        ts_r <= cfg_wr_data;
      end
      if (cmd.accept && (in_command == ppr_pkg::CMD_LOAD)) begin
        pos_x_r   <= in_pose_x;
        pos_y_r   <= in_pose_y;
        heading_r <= in_pose_yaw;
      end else if (cmd.update) begin
        pos_x_r   <= sat_val(sum_x);
        pos_y_r   <= sat_val(sum_y);
        heading_r <= sat_val(sum_q);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      step_r <= in_command;
      vx_r   <= in_vel_x;
      vy_r   <= in_vel_y;
      w_r    <= in_yaw_rate;
    end
    if (cmd.accept && (in_command == ppr_pkg::CMD_LOAD)) begin
      sat_r <= 1'b0;
    end else if (cmd.update) begin
      sat_r <= sat_hit(sum_x) | sat_hit(sum_y) | sat_hit(sum_q);
    end
    if (cmd.wrap) begin
      yaw_r <= yaw_nxt;
    end
    if (cmd.prep) begin
      x_r   <= ppr_pkg::GAIN_Q30;
      y_r   <= '0;
      z_r   <= z_prep_nxt;
      neg_r <= neg_nxt;
    end else if (cmd.rotate) begin
      x_r <= x_nxt;
      y_r <= y_nxt;
      z_r <= z_nxt;
    end
    if (cmd.mul_sel != ppr_pkg::MUL_NONE) begin
      prod_r <= prod_nxt;
    end
    unique case (cmd.acc_op)
      ppr_pkg::ACC_LOAD: acc_r <= prod_r;
      ppr_pkg::ACC_DX:   dx_r  <= term_nxt;
      ppr_pkg::ACC_DY:   dy_r  <= term_nxt;
      ppr_pkg::ACC_SX:   ddx_r <= ddx_nxt;
      ppr_pkg::ACC_SY:   ddy_r <= ddy_nxt;
      ppr_pkg::ACC_SQ:   ddq_r <= ddq_nxt;
      default: ;
    endcase
    if (cmd.finish) begin
      out_x_r   <= pos_x_r;
      out_y_r   <= pos_y_r;
      out_yaw_r <= heading_r;
      out_sat_r <= sat_r;
    end
  end

  assign status.step_item = step_r;
  assign out_x     = out_x_r;
  assign out_y     = out_y_r;
  assign out_yaw   = out_yaw_r;
  assign saturated = out_sat_r;

endmodule

`default_nettype wire

// ===== rtl/core/planar_pose_rollout.sv =====
// Planar pose integrator (x, y, yaw) with CORDIC heading rotation.
//
// Requests arrive on in_req (valid/ready). A load request (command 0) sets the
// pose from pose_x, pose_y, pose_yaw and echoes it with saturated low. A step
// request (command 1) wraps the stored yaw once into [-pi, pi], rotates the body
// velocity into the world frame and advances x, y and yaw by one sample period.
// Every request yields exactly one result on out_res (valid/ready). The sample period is
// written through cfg_wr_en/cfg_wr_data by the user only while idle, unchecked by the block.
//
// Sequence: a load request goes from acceptance through decode to finish, which
// registers its result, and the block then returns to idle. A step request also
// runs wrap, prep, the CORDIC iterations (one per cycle), seven passes through the
// single shared multiplier, rounding and the pose update before its finish state.
// The result sits in an output register, so a new request is accepted while it
// waits; if the receiver still stalls when the next result is done, the block
// holds that result internally and takes no request until the register frees.
// Synchronous reset clears the pose to zero, the sample period to about 10 ms,
// and leaves both channels empty with in_req ready.
`default_nettype none
`include "planar_pose_rollout_assert.svh"

module planar_pose_rollout #(
  parameter int CORDIC_STEPS = ppr_pkg::CORDIC_STEPS_DEFAULT
) (
  input  logic                       clk,
  input  logic                       rst_n,
  ppr_in_if.sink                     in_req,
  ppr_out_if.source                  out_res,
  input  logic                       cfg_wr_en,
  input  logic [ppr_pkg::DATA_W-1:0] cfg_wr_data
);

  // Command and status bundles between the sequencer and the datapath.
  ppr_pkg::ppr_cmd_t    ctrl_cmd;
  ppr_pkg::ppr_status_t dp_status;

  // The sequencer owns the handshakes; the datapath owns every payload bit.
  ppr_ctrl #(
    .CORDIC_STEPS(CORDIC_STEPS)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_req.valid),
    .in_ready  (in_req.ready),
    .out_valid (out_res.valid),
    .out_ready (out_res.ready),
    .status    (dp_status),
    .cmd       (ctrl_cmd)
  );

  ppr_datapath u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (ctrl_cmd),
    .status      (dp_status),
    .in_command  (in_req.command),
    .in_pose_x   (in_req.pose_x),
    .in_pose_y   (in_req.pose_y),
    .in_pose_yaw (in_req.pose_yaw),
    .in_vel_x    (in_req.vel_x),
    .in_vel_y    (in_req.vel_y),
    .in_yaw_rate (in_req.yaw_rate),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .out_x       (out_res.out_x),
    .out_y       (out_res.out_y),
    .out_yaw     (out_res.out_yaw),
    .saturated   (out_res.saturated)
  );

  // Reset empties the result register and leaves the block ready for a request.
  `PPR_ASSERT_RST(a_reset_state, !rst_n |=> (!out_res.valid && in_req.ready), "bad state after reset")
  // One request at a time: after an acceptance the block is busy.
  `PPR_ASSERT(a_busy_after_accept, (in_req.valid && in_req.ready) |=> !in_req.ready, "request accepted while busy")
  // A finished result never overwrites one the receiver has not taken.
  `PPR_ASSERT(a_no_overwrite, ctrl_cmd.finish |-> (!out_res.valid || out_res.ready), "pending result overwritten")

endmodule

`default_nettype wire

// ===== sim/tb.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for planar_pose_rollout: directed and random requests, checked
// against a bit-exact pose predictor. Needs ppr_pkg, ppr_in_if, ppr_out_if and the block.

module tb;

  // The predictor runs the same number of CORDIC iterations as the block instance.
  localparam int CORDIC_N = ppr_pkg::CORDIC_STEPS_DEFAULT;
  localparam int QUIET_LIMIT = 4000;
  localparam int PHASE_REQS = 155;

  // Angle constants of the step arithmetic: Q4.28 for the wrap, Q30 for the CORDIC.
  localparam longint PI_Q28_L = 843314857;
  localparam longint TWO_PI_Q28_L = 1686629713;
  localparam longint PI_Q30_L = 64'sd3373259426;
  localparam longint HALF_PI_Q30_L = 1686629713;
  localparam longint CORDIC_GAIN_Q30 = 652032874;
  localparam longint ROUND_Q30 = 536870912;
  localparam longint S32_MAX = 2147483647;
  localparam longint S32_MIN = -64'sd2147483648;
  localparam logic [31:0] PERIOD_AT_RESET = 32'd42949673;

  // atan(2^-i) in Q30.
  localparam longint ATAN_Q30 [0:29] = '{
    64'h3243F6A8, 64'h1DAC6705, 64'h0FADBAFC, 64'h07F56EA6, 64'h03FEAB76,
    64'h01FFD55B, 64'h00FFFAAA, 64'h007FFF55, 64'h003FFFEA, 64'h001FFFFD,
    64'h000FFFFF, 64'h0007FFFF, 64'h0003FFFF, 64'h0001FFFF, 64'h0000FFFF,
    64'h00007FFF, 64'h00003FFF, 64'h00001FFF, 64'h00000FFF, 64'h000007FF,
    64'h000003FF, 64'h000001FF, 64'h000000FF, 64'h0000007F, 64'h0000003F,
    64'h0000001F, 64'h0000000F, 64'h00000008, 64'h00000004, 64'h00000002
  };

  typedef struct packed {
    logic        command;
    logic [31:0] pose_x;
    logic [31:0] pose_y;
    logic [31:0] pose_yaw;
    logic [31:0] vel_x;
    logic [31:0] vel_y;
    logic [31:0] yaw_rate;
  } pose_req_t;

  typedef struct packed {
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] yaw;
    logic        sat;
  } pose_res_t;

  // One row of the directed table. When typed is set, want holds the pose that
  // can be read straight off the request; otherwise the predictor supplies it.
  typedef struct {
    pose_req_t rq;
    bit        typed;
    pose_res_t want;
  } directed_row_t;

  logic clk;
  logic rst_n;
  logic cfg_wr_en;
  logic [31:0] cfg_wr_data;

  ppr_in_if  in_req();
  ppr_out_if out_res();

  planar_pose_rollout #(.CORDIC_STEPS(CORDIC_N)) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_req     (in_req),
    .out_res    (out_res),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  // Predicted pose and sample period, plus the poses still owed by the block.
  logic signed [31:0] track_x;
  logic signed [31:0] track_y;
  logic signed [31:0] track_yaw;
  logic [31:0] period_q;
  pose_res_t pose_expect_q[$];
  directed_row_t directed_rows[$];

  int mismatch_count;
  int quiet_cycles;
  bit idle_on;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Magnitude of v, capped at 32 bits, times mul, shifted right by sh with the
  // magnitude rounded half away from zero; the sign is put back afterwards.
  function automatic longint round_scaled(input longint v, input longint unsigned mul,
                                          input int sh);
    longint unsigned mag;
    longint unsigned prod;
    mag = (v < 0) ? -v : v;
    if (mag > 64'hFFFF_FFFF) mag = 64'hFFFF_FFFF;
    prod = (mag * mul + (64'd1 << (sh - 1))) >> sh;
    return (v < 0) ? -longint'(prod) : longint'(prod);
  endfunction

  function automatic logic [31:0] clamp32(input longint v, inout bit hit);
    if (v > S32_MAX) begin
      hit = 1'b1;
      return S32_MAX[31:0];
    end
    if (v < S32_MIN) begin
      hit = 1'b1;
      return S32_MIN[31:0];
    end
    return v[31:0];
  endfunction

  // Applies one accepted request to the predicted pose and returns the pose the
  // block must report for it.
  function automatic pose_res_t advance_pose(input pose_req_t rq);
    pose_res_t res;
    longint vx, vy, w, yaw, z, cx, cy, nx, c, s, dx, dy, dq, px, py;
    bit flip;
    bit hit;
    hit = 1'b0;
    if (rq.command == ppr_pkg::CMD_LOAD) begin
      track_x = rq.pose_x;
      track_y = rq.pose_y;
      track_yaw = rq.pose_yaw;
    end else begin
      vx = $signed(rq.vel_x);
      vy = $signed(rq.vel_y);
      w = $signed(rq.yaw_rate);
      px = track_x;
      py = track_y;
      yaw = track_yaw;
      // A single correction by 2*pi; yaw values near the 32-bit limits stay outside
      // [-pi, pi] only if they were beyond 3*pi, which Q4.28 cannot hold.
      if (yaw > PI_Q28_L) yaw -= TWO_PI_Q28_L;
      else if (yaw < -PI_Q28_L) yaw += TWO_PI_Q28_L;
      // Rotation-mode CORDIC on the yaw in Q30, folded into [-pi/2, pi/2].
      z = yaw * 4;
      cx = CORDIC_GAIN_Q30;
      cy = 0;
      flip = 1'b0;
      if (z > HALF_PI_Q30_L) begin
        z -= PI_Q30_L;
        flip = 1'b1;
      end else if (z < -HALF_PI_Q30_L) begin
        z += PI_Q30_L;
        flip = 1'b1;
      end
      for (int i = 0; i < CORDIC_N && i < 30; i++) begin
        if (z >= 0) begin
          nx = cx - (cy >>> i);
          cy = cy + (cx >>> i);
          z -= ATAN_Q30[i];
        end else begin
          nx = cx + (cy >>> i);
          cy = cy - (cx >>> i);
          z += ATAN_Q30[i];
        end
        cx = nx;
      end
      c = flip ? -cx : cx;
      s = flip ? -cy : cy;
      // World-frame velocity, exact in Q46, rounded to Q16.16, then scaled by Ts.
      dx = (vx * c - vy * s + ROUND_Q30) >>> 30;
      dy = (vx * s + vy * c + ROUND_Q30) >>> 30;
      dx = round_scaled(dx, period_q, 32);
      dy = round_scaled(dy, period_q, 32);
      dq = round_scaled(w, period_q, 20);
      track_x = clamp32(px + dx, hit);
      track_y = clamp32(py + dy, hit);
      track_yaw = clamp32(yaw + dq, hit);
    end
    res.x = track_x;
    res.y = track_y;
    res.yaw = track_yaw;
    res.sat = hit;
    return res;
  endfunction

  function automatic pose_req_t load_req(input logic [31:0] x, input logic [31:0] y,
                                         input logic [31:0] yaw);
    pose_req_t rq;
    rq = {1'b0, x, y, yaw, $urandom(), $urandom(), $urandom()};
    rq.command = ppr_pkg::CMD_LOAD;
    return rq;
  endfunction

  function automatic pose_req_t step_req(input logic [31:0] vx, input logic [31:0] vy,
                                         input logic [31:0] w);
    pose_req_t rq;
    rq = {1'b0, $urandom(), $urandom(), $urandom(), vx, vy, w};
    rq.command = ppr_pkg::CMD_STEP;
    return rq;
  endfunction

  // A load echoes its pose, so its expectation is typed in with the row.
  task automatic add_load(input logic [31:0] x, input logic [31:0] y, input logic [31:0] yaw);
    directed_row_t row;
    row.rq = load_req(x, y, yaw);
    row.typed = 1'b1;
    row.want = {x, y, yaw, 1'b0};
    directed_rows.insert(directed_rows.size(), row);
  endtask

  task automatic add_step(input logic [31:0] vx, input logic [31:0] vy, input logic [31:0] w);
    directed_row_t row;
    row.rq = step_req(vx, vy, w);
    row.typed = 1'b0;
    row.want = '0;
    directed_rows.insert(directed_rows.size(), row);
  endtask

  // Uniform value in [-r, r], as a 32-bit two's complement pattern.
  function automatic logic [31:0] rand_span(input int unsigned r);
    return $urandom_range(0, 2 * r) - r;
  endfunction

  // Mostly realistic magnitudes, with full-range noise and the extremes mixed in.
  function automatic logic [31:0] rand_field(input int unsigned r);
    int unsigned pick;
    pick = $urandom_range(0, 19);
    if (pick < 3) begin
      case ($urandom_range(0, 3))
        0: return 32'h0000_0000;
        1: return 32'h7FFF_FFFF;
        2: return 32'h8000_0000;
        default: return 32'hFFFF_FFFF;
      endcase
    end
    if (pick < 8) return $urandom();
    return rand_span(r);
  endfunction

  // About one request in five reloads the pose; the rest integrate, so that long
  // chains of steps drive the pose toward the saturation limits now and then.
  function automatic pose_req_t make_request();
    pose_req_t rq;
    rq.command = ($urandom_range(0, 4) == 0) ? ppr_pkg::CMD_LOAD : ppr_pkg::CMD_STEP;
    rq.pose_x = rand_field(32'd6553600);
    rq.pose_y = rand_field(32'd6553600);
    rq.pose_yaw = rand_field(32'd1000000000);
    rq.vel_x = rand_field(32'd655360);
    rq.vel_y = rand_field(32'd655360);
    rq.yaw_rate = rand_field(32'd655360);
    return rq;
  endfunction

  // Idle stretches: mostly a few cycles, sometimes long.
  function automatic int unsigned idle_len();
    if ($urandom_range(0, 9) == 0) return $urandom_range(20, 60);
    return $urandom_range(1, 3);
  endfunction

  // Presents one request and holds it until the block takes it. The expectation
  // is queued at the accepting edge, before the result can possibly appear.
  task automatic send_request(input pose_req_t rq, input bit typed, input pose_res_t want);
    pose_res_t predicted;
    in_req.valid <= 1'b1;
    in_req.command <= rq.command;
    in_req.pose_x <= rq.pose_x;
    in_req.pose_y <= rq.pose_y;
    in_req.pose_yaw <= rq.pose_yaw;
    in_req.vel_x <= rq.vel_x;
    in_req.vel_y <= rq.vel_y;
    in_req.yaw_rate <= rq.yaw_rate;
    @(posedge clk);
    while (!in_req.ready) @(posedge clk);
    predicted = advance_pose(rq);
    pose_expect_q.insert(pose_expect_q.size(), typed ? want : predicted);
    // Either lower valid for a gap or leave it high for the next request.
    if (idle_on && $urandom_range(0, 2) == 0) begin
      in_req.valid <= 1'b0;
      repeat (idle_len()) @(posedge clk);
    end
  endtask

  // Holds off new requests until every outstanding result has been received; the
  // short pause afterwards lets the block settle back to idle.
  task automatic drain();
    in_req.valid <= 1'b0;
    while (pose_expect_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Register writes only happen with the block drained.
  task automatic write_period(input logic [31:0] value);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    period_q = value;
    @(posedge clk);
  endtask

  // Receiver side: ready is high most of the time; while idling is enabled it
  // drops for short and occasionally long stretches.
  initial begin
    forever begin
      if (idle_on && $urandom_range(0, 3) == 0) begin
        out_res.ready <= 1'b0;
        repeat (idle_len()) @(posedge clk);
      end else begin
        out_res.ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  // Every accepted result is matched against the oldest expectation.
  always @(posedge clk) begin : check_results
    pose_res_t want;
    if (rst_n && out_res.valid && out_res.ready) begin
      if (pose_expect_q.size() == 0) begin
        $error("unexpected result: x %h y %h yaw %h", out_res.out_x, out_res.out_y,
               out_res.out_yaw);
        mismatch_count++;
      end else begin
        want = pose_expect_q.pop_front();
        if (out_res.out_x !== want.x) begin
          $error("out_x: expected %h, got %h", want.x, out_res.out_x);
          mismatch_count++;
        end
        if (out_res.out_y !== want.y) begin
          $error("out_y: expected %h, got %h", want.y, out_res.out_y);
          mismatch_count++;
        end
        if (out_res.out_yaw !== want.yaw) begin
          $error("out_yaw: expected %h, got %h", want.yaw, out_res.out_yaw);
          mismatch_count++;
        end
        if (out_res.saturated !== want.sat) begin
          $error("saturated: expected %b, got %b", want.sat, out_res.saturated);
          mismatch_count++;
        end
      end
    end
  end

  // Watchdog: a healthy run never goes this long without a handshake on either side.
  always @(posedge clk) begin
    if (!rst_n || (in_req.valid && in_req.ready) || (out_res.valid && out_res.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("tb: done, errors");
      $finish;
    end
  end

  initial begin : stimulus
    logic [31:0] phase_period [0:7];
    directed_row_t row;
    mismatch_count = 0;
    idle_on = 1'b1;
    track_x = '0;
    track_y = '0;
    track_yaw = '0;
    period_q = PERIOD_AT_RESET;

    rst_n <= 1'b0;
    cfg_wr_en <= 1'b0;
    cfg_wr_data <= '0;
    in_req.valid <= 1'b0;
    in_req.command <= ppr_pkg::CMD_LOAD;
    in_req.pose_x <= '0;
    in_req.pose_y <= '0;
    in_req.pose_yaw <= '0;
    in_req.vel_x <= '0;
    in_req.vel_y <= '0;
    in_req.yaw_rate <= '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed table, run at the reset sample period. The first step right after
    // reset, with zero velocities, must leave the cleared pose untouched.
    row.rq = step_req(32'h0, 32'h0, 32'h0);
    row.typed = 1'b1;
    row.want = '0;
    directed_rows.insert(directed_rows.size(), row);
    // Field extremes, including a yaw far beyond pi that the next step wraps.
    add_load(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    add_step(32'h7FFF_FFFF, 32'h0, 32'h7FFF_FFFF);
    add_load(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    add_step(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    // Yaw exactly at +pi is left alone; one count above it is wrapped down.
    add_load(32'h0, 32'h0, 32'd843314857);
    add_step(32'h0001_0000, 32'h0, 32'h0);
    add_load(32'h0, 32'h0, 32'd843314858);
    add_step(32'h0001_0000, 32'h0001_0000, 32'h0);
    // The same pair at -pi, which wraps upward.
    add_load(32'h0, 32'h0, -32'sd843314857);
    add_step(32'h0, 32'h0001_0000, 32'h0);
    add_load(32'h0, 32'h0, -32'sd843314858);
    add_step(32'hFFFF_0000, 32'h0001_0000, 32'h0);
    // Position saturation in both directions at once.
    add_load(32'h7FFF_FFF0, 32'h8000_0010, 32'h0);
    add_step(32'h7FFF_FFFF, 32'h8000_0000, 32'h0);
    // Heading saturation from a large yaw rate.
    add_load(32'h0, 32'h0, 32'h7FFF_FFF0);
    add_step(32'h0, 32'h0, 32'h7FFF_FFFF);
    // Just inside and just outside the CORDIC quadrant fold at pi/2.
    add_load(32'h0, 32'h0, 32'd421657428);
    add_step(32'h0001_0000, 32'h0001_0000, 32'h0001_0000);
    add_load(32'h0, 32'h0, 32'd421657429);
    add_step(32'h0001_0000, 32'h0001_0000, 32'h0001_0000);
    // Alternating bit patterns through every pose field.
    add_load(32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA);
    add_load(32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555);

    foreach (directed_rows[i]) begin
      send_request(directed_rows[i].rq, directed_rows[i].typed, directed_rows[i].want);
    end
    drain();

    // Random phases, each at its own sample period: both extremes, a zero period
    // (steps then only wrap the yaw), full-range noise, a realistic control-loop
    // range, and the reset value again. Every third phase runs without idling.
    phase_period[0] = 32'hFFFF_FFFF;
    phase_period[1] = 32'd1;
    phase_period[2] = 32'd0;
    phase_period[3] = $urandom();
    phase_period[4] = $urandom_range(32'd4294967, 32'd429496730);
    phase_period[5] = $urandom_range(32'd4294967, 32'd429496730);
    phase_period[6] = $urandom();
    phase_period[7] = PERIOD_AT_RESET;
    for (int p = 0; p < 8; p++) begin
      idle_on = (p % 3) != 1;
      write_period(phase_period[p]);
      for (int n = 0; n < PHASE_REQS; n++) begin
        send_request(make_request(), 1'b0, '0);
        // Now and then the sender waits for the block to empty completely.
        if ($urandom_range(0, 99) == 0) drain();
      end
      drain();
    end

    // Let any stray result show up before the verdict.
    idle_on = 1'b0;
    repeat (60) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

endmodule
